// File: src/nslf_pkg.sv
// nslf_pkg: types, character codes and header table for the sentence log filter
// no dependencies; used by nslf_result_if, nslf_cfg_if, nslf_line_track and the top level
package nslf_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 10;
	localparam int COL_W       = 5;
	localparam int SYNC_W      = 10;
	localparam int LEN_W       = 10;
	localparam int UTC_W       = 7;

	// register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_RMC_STATUS_COL = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GGA_FIX_COL    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RMC_TIME_COL   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RMC_DATE_COL   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SYNC_PERIOD    = 3'd4;

	// register values after reset
	localparam logic [COL_W-1:0]  RST_RMC_STATUS_COL = 5'd2;
	localparam logic [COL_W-1:0]  RST_GGA_FIX_COL    = 5'd6;
	localparam logic [COL_W-1:0]  RST_RMC_TIME_COL   = 5'd1;
	localparam logic [COL_W-1:0]  RST_RMC_DATE_COL   = 5'd9;
	localparam logic [SYNC_W-1:0] RST_SYNC_PERIOD    = 10'd90;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_A      = 8'h41;

	// sentence kind codes
	localparam logic [1:0] KIND_OTHER = 2'd0;
	localparam logic [1:0] KIND_RMC   = 2'd1;
	localparam logic [1:0] KIND_GGA   = 2'd2;

	// verdict codes
	localparam logic [1:0] VERDICT_DROP  = 2'd0;
	localparam logic [1:0] VERDICT_LOG   = 2'd1;
	localparam logic [1:0] VERDICT_ENTER = 2'd2;

	localparam int NUM_HDR = 6;
	localparam int HDR_LEN = 6;

	// first three entries are rmc headers, last three gga headers
	localparam logic [0:NUM_HDR-1][8*HDR_LEN-1:0] HDR_TAB = '{
		"$GPRMC", "$GQRMC", "$GNRMC", "$GPGGA", "$GQGGA", "$GNGGA"
	};

	typedef struct packed {
		logic [COL_W-1:0] rmc_status_col;
		logic [COL_W-1:0] gga_fix_col;
		logic [COL_W-1:0] rmc_time_col;
		logic [COL_W-1:0] rmc_date_col;
	} col_cfg_t;

	// summary of a line finished by the byte in the input register
	typedef struct packed {
		logic                         done;
		logic [LEN_W-1:0]             length;
		logic                         is_rmc;
		logic                         is_gga;
		logic                         status_a;
		logic                         fix_good;
		logic [5:0][UTC_W-1:0]        utc;
	} line_sum_t;

	function automatic logic [7:0] hdr_char(input logic [2:0] k, input logic [2:0] p);
		logic [7:0] ch;
		ch = 8'h00;
		if (k < 3'(NUM_HDR) && p < 3'(HDR_LEN)) begin
			ch = HDR_TAB[k][8*HDR_LEN-1 - 8*p -: 8];
		end
		return ch;
	endfunction

endpackage

// File: src/nslf_rx_if.sv
// nslf_rx_if: valid/ready channel carrying one received byte
// depends on nothing
interface nslf_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

// File: src/nslf_result_if.sv
// nslf_result_if: valid/ready channel carrying one line result
// depends on nslf_pkg for field widths
interface nslf_result_if;
	logic                           valid;
	logic                           ready;
	logic [nslf_pkg::LEN_W-1:0]     line_length;
	logic [1:0]                     sentence_kind;
	logic [1:0]                     verdict;
	logic                           sync_pulse;
	logic [nslf_pkg::UTC_W-1:0]     utc_hour;
	logic [nslf_pkg::UTC_W-1:0]     utc_minute;
	logic [nslf_pkg::UTC_W-1:0]     utc_second;
	logic [nslf_pkg::UTC_W-1:0]     utc_day;
	logic [nslf_pkg::UTC_W-1:0]     utc_month;
	logic [nslf_pkg::UTC_W-1:0]     utc_year;

	modport source(output valid, output line_length, output sentence_kind, output verdict,
		output sync_pulse, output utc_hour, output utc_minute, output utc_second,
		output utc_day, output utc_month, output utc_year, input ready);
	modport sink(input valid, input line_length, input sentence_kind, input verdict,
		input sync_pulse, input utc_hour, input utc_minute, input utc_second,
		input utc_day, input utc_month, input utc_year, output ready);
endinterface

// File: src/nslf_cfg_if.sv
// nslf_cfg_if: register write channel, index and data with valid/ready
// depends on nslf_pkg for field widths
interface nslf_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [nslf_pkg::CFG_INDEX_W-1:0]   index;
	logic [nslf_pkg::CFG_DATA_W-1:0]    data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// File: src/nslf_line_track.sv
// nslf_line_track: per-line state (header match, column search, time/date digits)
// depends on nslf_pkg; instantiated by nmea_sentence_log_filter_top
module nslf_line_track #(
	parameter int LINE_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [7:0]           rx_byte,
	input  nslf_pkg::col_cfg_t   cols,
	output nslf_pkg::line_sum_t  sum
);

	localparam int CW = $clog2(LINE_DEPTH + 1);
	localparam int LW = (CW > nslf_pkg::LEN_W) ? CW : nslf_pkg::LEN_W;

	logic                 in_line_q;
	logic [CW-1:0]        cnt_q;
	logic [4:0]           comma_q;
	logic                 cut_q;
	logic                 prev_comma_q;
	logic [5:0]           hdr_q;
	logic [7:0]           status_char_q;
	logic [7:0]           fix_char_q;
	logic                 status_ok_q;
	logic                 fix_ok_q;
	logic [11:0][3:0]     digit_q;
	logic [11:0]          dok_q;
	logic [2:0]           tleft_q;
	logic [2:0]           dleft_q;

	logic                 take;
	logic                 start;
	logic [CW-1:0]        cur_cnt;
	logic [4:0]           cur_comma;
	logic                 cur_cut;
	logic                 cur_prev;
	logic [5:0]           cur_hdr;
	logic [7:0]           cur_sc;
	logic [7:0]           cur_fc;
	logic                 cur_sok;
	logic                 cur_fok;
	logic [11:0][3:0]     cur_dig;
	logic [11:0]          cur_dok;
	logic [2:0]           cur_tl;
	logic [2:0]           cur_dl;

	logic                 first;
	logic [2:0]           tl;
	logic [2:0]           dl;
	logic [3:0]           tslot;
	logic [3:0]           dslot;
	logic                 is_digit;

	logic                 n_in_line;
	logic [CW-1:0]        n_cnt;
	logic [4:0]           n_comma;
	logic                 n_cut;
	logic                 n_prev;
	logic [5:0]           n_hdr;
	logic [7:0]           n_sc;
	logic [7:0]           n_fc;
	logic                 n_sok;
	logic                 n_fok;
	logic [11:0][3:0]     n_dig;
	logic [11:0]          n_dok;
	logic [2:0]           n_tl;
	logic [2:0]           n_dl;
	logic                 full;
	logic [LW-1:0]        cnt_w;
	logic [7:0]           pair;

	function automatic logic at_col(input logic [4:0] col, input logic cut,
		input logic [4:0] cc, input logic prev, input logic at_first);
		logic hit;
		hit = 1'b0;
		if (!cut && cc == col) begin
			hit = (col == 5'd0) ? at_first : prev;
		end
		return hit;
	endfunction

	// a dollar outside a line opens a fresh one
	assign take  = (rx_byte != nslf_pkg::CH_NUL) &&
		(in_line_q || rx_byte == nslf_pkg::CH_DOLLAR);
	assign start = !in_line_q;

	always_comb begin
		if (start) begin
			cur_cnt   = '0;
			cur_comma = '0;
			cur_cut   = 1'b0;
			cur_prev  = 1'b0;
			cur_hdr   = '1;
			cur_sc    = '0;
			cur_fc    = '0;
			cur_sok   = 1'b0;
			cur_fok   = 1'b0;
			cur_dig   = '0;
			cur_dok   = '0;
			cur_tl    = '0;
			cur_dl    = '0;
		end else begin
			cur_cnt   = cnt_q;
			cur_comma = comma_q;
			cur_cut   = cut_q;
			cur_prev  = prev_comma_q;
			cur_hdr   = hdr_q;
			cur_sc    = status_char_q;
			cur_fc    = fix_char_q;
			cur_sok   = status_ok_q;
			cur_fok   = fix_ok_q;
			cur_dig   = digit_q;
			cur_dok   = dok_q;
			cur_tl    = tleft_q;
			cur_dl    = dleft_q;
		end
	end

	always_comb begin
		first    = (cur_cnt == '0);
		is_digit = (rx_byte >= nslf_pkg::CH_ZERO) && (rx_byte <= nslf_pkg::CH_NINE);

		// header compare over the first six bytes
		n_hdr = cur_hdr;
		if (cur_cnt < CW'(nslf_pkg::HDR_LEN)) begin
			for (int k = 0; k < nslf_pkg::NUM_HDR; k++) begin
				if (rx_byte != nslf_pkg::hdr_char(3'(k), cur_cnt[2:0])) begin
					n_hdr[k] = 1'b0;
				end
			end
		end

		// time and date capture windows of six bytes each
		tl = at_col(cols.rmc_time_col, cur_cut, cur_comma, cur_prev, first) ? 3'd6 : cur_tl;
		dl = at_col(cols.rmc_date_col, cur_cut, cur_comma, cur_prev, first) ? 3'd6 : cur_dl;
		tslot = 4'd6 - {1'b0, tl};
		dslot = 4'd12 - {1'b0, dl};
		n_dig = cur_dig;
		n_dok = cur_dok;
		for (int s = 0; s < 12; s++) begin
			if ((tl != 3'd0 && tslot == 4'(s)) || (dl != 3'd0 && dslot == 4'(s))) begin
				n_dig[s] = rx_byte[3:0];
				if (is_digit) begin
					n_dok[s] = 1'b1;
				end
			end
		end
		n_tl = (tl != 3'd0) ? tl - 3'd1 : 3'd0;
		n_dl = (dl != 3'd0) ? dl - 3'd1 : 3'd0;

		n_sc  = cur_sc;
		n_sok = cur_sok;
		if (at_col(cols.rmc_status_col, cur_cut, cur_comma, cur_prev, first)) begin
			n_sc  = rx_byte;
			n_sok = 1'b1;
		end
		n_fc  = cur_fc;
		n_fok = cur_fok;
		if (at_col(cols.gga_fix_col, cur_cut, cur_comma, cur_prev, first)) begin
			n_fc  = rx_byte;
			n_fok = 1'b1;
		end

		// comma counting stops at the first control or space byte
		n_comma = cur_comma;
		n_cut   = cur_cut;
		n_prev  = 1'b0;
		if (!cur_cut) begin
			if (rx_byte <= nslf_pkg::CH_SPACE) begin
				n_cut = 1'b1;
			end else if (rx_byte == nslf_pkg::CH_COMMA && cur_comma != 5'd31) begin
				n_comma = cur_comma + 5'd1;
				n_prev  = 1'b1;
			end
		end

		n_cnt = cur_cnt + CW'(1);
		full  = (n_cnt >= CW'(LINE_DEPTH));
		n_in_line = take ? (!full && rx_byte != nslf_pkg::CH_NL) : in_line_q;

		cnt_w = LW'(n_cnt);
		sum.done     = take && !full && (rx_byte == nslf_pkg::CH_NL);
		sum.length   = (cnt_w > LW'(1023)) ? 10'd1023 : cnt_w[nslf_pkg::LEN_W-1:0];
		sum.is_rmc   = |n_hdr[2:0];
		sum.is_gga   = |n_hdr[5:3];
		sum.status_a = n_sok && (n_sc == nslf_pkg::CH_A);
		sum.fix_good = n_fok && (n_fc != nslf_pkg::CH_ZERO);
		for (int j = 0; j < 6; j++) begin
			pair = ({4'd0, n_dig[2*j]} << 3) + ({4'd0, n_dig[2*j]} << 1) +
				{4'd0, n_dig[2*j+1]};
			sum.utc[j] = (sum.is_rmc && n_dok[2*j] && n_dok[2*j+1]) ?
				pair[nslf_pkg::UTC_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_line_q    <= 1'b0;
			cnt_q        <= '0;
			comma_q      <= '0;
			cut_q        <= 1'b0;
			prev_comma_q <= 1'b0;
			hdr_q        <= '1;
			status_ok_q  <= 1'b0;
			fix_ok_q     <= 1'b0;
			dok_q        <= '0;
			tleft_q      <= '0;
			dleft_q      <= '0;
		end else if (en && take) begin
			in_line_q    <= n_in_line;
			cnt_q        <= n_cnt;
			comma_q      <= n_comma;
			cut_q        <= n_cut;
			prev_comma_q <= n_prev;
			hdr_q        <= n_hdr;
			status_ok_q  <= n_sok;
			fix_ok_q     <= n_fok;
			dok_q        <= n_dok;
			tleft_q      <= n_tl;
			dleft_q      <= n_dl;
		end
	end

	always_ff @(posedge clk) begin
		if (en && take) begin
			status_char_q <= n_sc;
			fix_char_q    <= n_fc;
			digit_q       <= n_dig;
		end
	end

endmodule

// File: src/nmea_sentence_log_filter_top.sv
// nmea_sentence_log_filter_top: byte-stream sentence filter with log/sync decisions
// depends on nslf_pkg, nslf_rx_if, nslf_result_if, nslf_cfg_if and nslf_line_track
// a newline is held in the input byte register; its result is then captured in the free result register
// throughput: one byte per cycle; the byte register advances whenever the result
// register is free or the byte finishes no line, so only a held result stalls input
// reset: asynchronous, active low; clears line search, standby mode, sync count and
// restores the register defaults; the configuration port is always ready
module nmea_sentence_log_filter_top #(
	parameter int LINE_DEPTH = 1024
) (
	input logic              clk,
	input logic              arst_n,
	nslf_rx_if.sink          rx,
	nslf_result_if.source    result,
	nslf_cfg_if.sink         cfg
);

	// configuration registers
	nslf_pkg::col_cfg_t                 cols_q;
	logic [nslf_pkg::SYNC_W-1:0]        sync_period_q;

	// input byte register
	logic                               rx_valid_s1;
	logic [7:0]                         rx_byte_s1;

	// mode and sync counter
	logic                               logging_q;
	logic [nslf_pkg::SYNC_W-1:0]        sync_count_q;

	// result register
	logic                               res_valid_q;
	logic [nslf_pkg::LEN_W-1:0]         len_q;
	logic [1:0]                         kind_q;
	logic [1:0]                         verdict_q;
	logic                               pulse_q;
	logic [5:0][nslf_pkg::UTC_W-1:0]    utc_q;

	nslf_pkg::line_sum_t                sum;
	logic                               line_done;
	logic                               advance;
	logic [1:0]                         kind;
	logic [1:0]                         verdict;
	logic                               pulse;

	nslf_line_track #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_line_track (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.rx_byte(rx_byte_s1),
		.cols   (cols_q),
		.sum    (sum)
	);

	// a finished line needs a free result slot, anything else moves on at once
	assign line_done = rx_valid_s1 && sum.done;
	assign advance   = rx_valid_s1 && (!sum.done || !res_valid_q || result.ready);
	assign rx.ready  = !rx_valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// sentence kind, rmc wins over gga
	always_comb begin
		if (sum.is_rmc) begin
			kind = nslf_pkg::KIND_RMC;
		end else if (sum.is_gga) begin
			kind = nslf_pkg::KIND_GGA;
		end else begin
			kind = nslf_pkg::KIND_OTHER;
		end
	end

	// verdict: standby waits for a valid rmc, logging keeps good rmc and gga lines
	always_comb begin
		verdict = nslf_pkg::VERDICT_DROP;
		if (!logging_q) begin
			if (sum.is_rmc && sum.status_a) begin
				verdict = nslf_pkg::VERDICT_ENTER;
			end
		end else if (sum.is_gga) begin
			if (sum.fix_good) begin
				verdict = nslf_pkg::VERDICT_LOG;
			end
		end else if (sum.is_rmc) begin
			if (sum.status_a) begin
				verdict = nslf_pkg::VERDICT_LOG;
			end
		end
	end

	// sync pulse once every period+1 lines, only while logging
	assign pulse = logging_q && (sync_count_q >= sync_period_q);

	// configuration writes; indexes past the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q.rmc_status_col <= nslf_pkg::RST_RMC_STATUS_COL;
			cols_q.gga_fix_col    <= nslf_pkg::RST_GGA_FIX_COL;
			cols_q.rmc_time_col   <= nslf_pkg::RST_RMC_TIME_COL;
			cols_q.rmc_date_col   <= nslf_pkg::RST_RMC_DATE_COL;
			sync_period_q         <= nslf_pkg::RST_SYNC_PERIOD;
		end else if (cfg.valid) begin
			case (cfg.index)
				nslf_pkg::REG_RMC_STATUS_COL: begin
					cols_q.rmc_status_col <= cfg.data[nslf_pkg::COL_W-1:0];
				end
				nslf_pkg::REG_GGA_FIX_COL: begin
					cols_q.gga_fix_col <= cfg.data[nslf_pkg::COL_W-1:0];
				end
				nslf_pkg::REG_RMC_TIME_COL: begin
					cols_q.rmc_time_col <= cfg.data[nslf_pkg::COL_W-1:0];
				end
				nslf_pkg::REG_RMC_DATE_COL: begin
					cols_q.rmc_date_col <= cfg.data[nslf_pkg::COL_W-1:0];
				end
				nslf_pkg::REG_SYNC_PERIOD: begin
					sync_period_q <= cfg.data[nslf_pkg::SYNC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// input byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			rx_valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	// logging mode is left only by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			logging_q    <= 1'b0;
			sync_count_q <= '0;
		end else if (advance && line_done) begin
			if (!logging_q) begin
				if (verdict == nslf_pkg::VERDICT_ENTER) begin
					logging_q <= 1'b1;
				end
			end else if (pulse) begin
				sync_count_q <= '0;
			end else begin
				sync_count_q <= sync_count_q + 10'd1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && line_done) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && line_done) begin
			len_q     <= sum.length;
			kind_q    <= kind;
			verdict_q <= verdict;
			pulse_q   <= pulse;
			utc_q     <= sum.utc;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.line_length   = len_q;
	assign result.sentence_kind = kind_q;
	assign result.verdict       = verdict_q;
	assign result.sync_pulse    = pulse_q;
	assign result.utc_hour      = utc_q[0];
	assign result.utc_minute    = utc_q[1];
	assign result.utc_second    = utc_q[2];
	assign result.utc_day       = utc_q[3];
	assign result.utc_month     = utc_q[4];
	assign result.utc_year      = utc_q[5];

endmodule
